/* hdl/fbc_pkg.sv */
package fbc_pkg;

   typedef enum logic [1:0] {
      OP_FETCH   = 2'd0,
      OP_STORE   = 2'd1,
      OP_COMPACT = 2'd2
   } fbc_op_type;

   typedef enum logic [1:0] {
      KIND_HIT     = 2'd0,
      KIND_MISS    = 2'd1,
      KIND_EVICTED = 2'd2,
      KIND_NONE    = 2'd3
   } fbc_kind_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_FETCH,
      ST_STORE,
      ST_COMPACT
   } fbc_state_type;

   localparam logic [1:0] REG_ENABLE     = 2'd0;
   localparam logic [1:0] REG_MAX_BYTES  = 2'd1;
   localparam logic [1:0] REG_MAX_BLOCKS = 2'd2;
   localparam logic [1:0] REG_MAX_AGE    = 2'd3;

   localparam logic [4:0]  RST_MAX_BLOCKS = 5'd16;
   localparam logic [33:0] SMALL_LIMIT    = 34'd131072;
   localparam logic [33:0] ROUND_SMALL    = 34'd1023;
   localparam logic [33:0] ROUND_LARGE    = 34'd4095;

   typedef struct packed {
      logic        valid;
      logic [31:0] handle;
      logic [31:0] size;
      logic [31:0] stamp;
   } fbc_entry_type;

   // command broadcast to every cell
   typedef struct packed {
      logic        evict;
      logic        remove;
      logic        append;
      logic [31:0] key;
      logic [31:0] new_handle;
      logic [31:0] new_size;
      logic [31:0] new_stamp;
   } fbc_cmd_type;

   // what the row shows back to the controller
   typedef struct packed {
      logic          hit;
      logic [31:0]   hit_handle;
      fbc_entry_type head;
   } fbc_view_type;

endpackage

/* hdl/fbc_cell.sv */
module fbc_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  fbc_pkg::fbc_cmd_type  cmd,
   input  logic                  shift,
   input  logic                  left_valid,
   input  fbc_pkg::fbc_entry_type right,
   output fbc_pkg::fbc_entry_type ent,
   output logic                  match
);

   fbc_pkg::fbc_entry_type ent_ff;
   fbc_pkg::fbc_entry_type ent_in;
   logic                   slot;

   // after a shift the free slot sits one place further down
   always_comb begin
      slot = cmd.append && (shift ? (ent_ff.valid && !right.valid)
                                  : (left_valid && !ent_ff.valid));
      ent_in = ent_ff;
      if (shift) begin
         ent_in = right;
      end
      if (slot) begin
         ent_in.valid  = 1'b1;
         ent_in.handle = cmd.new_handle;
         ent_in.size   = cmd.new_size;
         ent_in.stamp  = cmd.new_stamp;
      end
   end

   always_ff @(posedge clock) begin
      ent_ff.handle <= ent_in.handle;
      ent_ff.size   <= ent_in.size;
      ent_ff.stamp  <= ent_in.stamp;
      if (reset) begin
         ent_ff.valid <= 1'b0;
      end else begin
         ent_ff.valid <= ent_in.valid;
      end
   end

   assign ent   = ent_ff;
   assign match = ent_ff.valid && (ent_ff.size == cmd.key);

endmodule

/* hdl/fbc_array.sv */
module fbc_array #(
   parameter int DEPTH = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  fbc_pkg::fbc_cmd_type  cmd,
   output fbc_pkg::fbc_view_type view
);

   fbc_pkg::fbc_entry_type ents [DEPTH];
   logic [DEPTH-1:0]       match;
   logic [DEPTH-1:0]       above;
   logic [DEPTH-1:0]       hit_onehot;
   logic [DEPTH-1:0]       shift;
   logic                   any_hit;
   logic [31:0]            hit_handle;

   assign any_hit = |match;

   // oldest entry in cell 0, newest at the top of the valid run
   for (genvar j = 0; j < DEPTH; j++) begin : g_cell
      fbc_pkg::fbc_entry_type right;
      logic                   left_valid;

      if (j == DEPTH - 1) begin : g_top
         assign above[j] = 1'b0;
         assign right    = '0;
      end else begin : g_mid
         assign above[j] = |match[DEPTH-1:j+1];
         assign right    = ents[j+1];
      end

      if (j == 0) begin : g_first
         assign left_valid = 1'b1;
      end else begin : g_rest
         assign left_valid = ents[j-1].valid;
      end

      assign hit_onehot[j] = match[j] && !above[j];
      // every cell shifts on an eviction; on a removal, cells at and above the newest match close the gap
      assign shift[j] = cmd.evict || (cmd.remove && any_hit && !above[j]);

      fbc_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cmd        (cmd),
         .shift      (shift[j]),
         .left_valid (left_valid),
         .right      (right),
         .ent        (ents[j]),
         .match      (match[j])
      );
   end

   always_comb begin
      hit_handle = '0;
      for (int i = 0; i < DEPTH; i++) begin
         hit_handle = hit_handle | (hit_onehot[i] ? ents[i].handle : 32'd0);
      end
   end

   assign view.hit        = any_hit;
   assign view.hit_handle = hit_handle;
   assign view.head       = ents[0];

endmodule

/* hdl/free_block_cache_policy_top.sv */
// Recency-ordered cache of freed buffers, held in a row of DEPTH cells with the
// oldest entry in the first cell. One item is worked on at a time and the next
// is taken once every result of the current one has been handed to the output
// register. In a fetch the size is rounded as the item is taken, then every cell
// compares against it at once and the newest match is removed while the single
// result is written out. A store appends the block, and when the row is full the
// oldest block leaves as the new one goes in; the store then goes on as a compact
// does, evicting the oldest block while disabled or over a limit, at most DEPTH
// times per item. Evictions always leave from the first cell, so the row gives one
// evicted handle per cycle while the result side keeps taking them; a stalled
// result side holds them back. Opcode 3 is taken and dropped without a result.
// Limit registers may be written between items and act on the next store or
// compact. The row needs no clearing pass after reset.
module free_block_cache_policy_top #(
   parameter int DEPTH        = 16,
   parameter int HEADER_BYTES = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [1:0]   req_tuser,  // opcode
   input  logic [63:0]  req_tdata,  // request_bytes, block_handle
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [1:0]   rsp_tuser,  // result_kind
   output logic         rsp_tlast,  // last_result
   // out_handle, out_size, bytes_held, hit_count, miss_count, 4 bits zero
   output logic [167:0] rsp_tdata,
   input  logic         csr_we,
   input  logic [1:0]   csr_addr,
   input  logic [35:0]  csr_wdata
);

   localparam int          CW  = $clog2(DEPTH + 1);
   localparam int          BW  = (CW > 5) ? CW : 5;
   localparam logic [33:0] HDR = 34'(HEADER_BYTES);

   fbc_pkg::fbc_state_type state_ff, state_in;
   fbc_pkg::fbc_cmd_type   cmd;
   fbc_pkg::fbc_view_type  view;

   logic          en_ff;
   logic [35:0]   max_bytes_ff;
   logic [4:0]    max_blocks_ff;
   logic [31:0]   max_age_ff;

   logic [31:0]   key_ff, key_in;
   logic          oversize_ff, oversize_in;
   logic [31:0]   size_ff, size_in;
   logic [31:0]   handle_ff, handle_in;
   logic [31:0]   clk_ff, clk_in;
   logic [35:0]   cached_ff, cached_in;
   logic [31:0]   hits_ff, hits_in;
   logic [31:0]   miss_ff, miss_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [CW-1:0] k_ff, k_in;

   logic          pend_valid_ff, pend_valid_in;
   logic [31:0]   pend_handle_ff, pend_handle_in;
   logic [31:0]   pend_size_ff, pend_size_in;
   logic [35:0]   pend_bytes_ff, pend_bytes_in;

   logic          rsp_valid_ff, rsp_valid_in;
   logic [1:0]    rsp_kind_ff, rsp_kind_in;
   logic [31:0]   rsp_handle_ff, rsp_handle_in;
   logic [31:0]   rsp_size_ff, rsp_size_in;
   logic [35:0]   rsp_bytes_ff, rsp_bytes_in;
   logic [31:0]   rsp_hits_ff, rsp_hits_in;
   logic [31:0]   rsp_miss_ff, rsp_miss_in;
   logic          rsp_last_ff, rsp_last_in;

   logic          accept;
   logic          out_free;
   logic          emit;
   logic          over_limit;
   logic          can_evict;
   logic [31:0]   age;
   logic [33:0]   total_w;
   logic [33:0]   rnd_w;
   logic [33:0]   key_w;

   assign req_tready = (state_ff == fbc_pkg::ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   // header on, round to 1k or 4k granules, header off
   always_comb begin
      total_w = 34'(req_tdata[31:0]) + HDR;
      if (total_w <= fbc_pkg::SMALL_LIMIT) begin
         rnd_w = (total_w + fbc_pkg::ROUND_SMALL) & ~fbc_pkg::ROUND_SMALL;
      end else begin
         rnd_w = (total_w + fbc_pkg::ROUND_LARGE) & ~fbc_pkg::ROUND_LARGE;
      end
      key_w = rnd_w - HDR;
   end

   assign age        = clk_ff - view.head.stamp;
   assign over_limit = (cnt_ff != '0) &&
                       (!en_ff || (age > max_age_ff) || (cached_ff > max_bytes_ff) ||
                        (BW'(cnt_ff) > BW'(max_blocks_ff)));
   assign can_evict  = over_limit && (k_ff < CW'(DEPTH));

   always_comb begin
      state_in       = state_ff;
      key_in         = key_ff;
      oversize_in    = oversize_ff;
      size_in        = size_ff;
      handle_in      = handle_ff;
      clk_in         = clk_ff;
      cached_in      = cached_ff;
      hits_in        = hits_ff;
      miss_in        = miss_ff;
      cnt_in         = cnt_ff;
      k_in           = k_ff;
      pend_valid_in  = pend_valid_ff;
      pend_handle_in = pend_handle_ff;
      pend_size_in   = pend_size_ff;
      pend_bytes_in  = pend_bytes_ff;

      cmd            = '0;
      cmd.key        = key_ff;
      cmd.new_handle = handle_ff;
      cmd.new_size   = size_ff;
      cmd.new_stamp  = clk_ff;

      emit        = 1'b0;
      rsp_kind_in = fbc_pkg::KIND_NONE;
      rsp_handle_in = '0;
      rsp_size_in = '0;
      rsp_bytes_in = cached_ff;
      rsp_hits_in = hits_ff;
      rsp_miss_in = miss_ff;
      rsp_last_in = 1'b1;

      unique case (state_ff)
         fbc_pkg::ST_IDLE: begin
            if (accept) begin
               key_in      = key_w[31:0];
               oversize_in = |key_w[33:32];
               size_in     = req_tdata[31:0];
               handle_in   = req_tdata[63:32];
               k_in        = '0;
               unique case (fbc_pkg::fbc_op_type'(req_tuser))
                  fbc_pkg::OP_FETCH: begin
                     state_in = fbc_pkg::ST_FETCH;
                  end
                  fbc_pkg::OP_STORE: begin
                     clk_in   = clk_ff + 32'd1;
                     state_in = fbc_pkg::ST_STORE;
                  end
                  fbc_pkg::OP_COMPACT: begin
                     state_in = fbc_pkg::ST_COMPACT;
                  end
                  default: begin
                     state_in = fbc_pkg::ST_IDLE;
                  end
               endcase
            end
         end

         fbc_pkg::ST_FETCH: begin
            if (out_free) begin
               emit     = 1'b1;
               state_in = fbc_pkg::ST_IDLE;
               if (oversize_ff) begin
                  miss_in       = miss_ff + 32'd1;
                  rsp_kind_in   = fbc_pkg::KIND_MISS;
                  rsp_size_in   = '1;
               end else if (view.hit) begin
                  cmd.remove    = 1'b1;
                  cached_in     = cached_ff - 36'(key_ff);
                  hits_in       = hits_ff + 32'd1;
                  cnt_in        = cnt_ff - CW'(1);
                  rsp_kind_in   = fbc_pkg::KIND_HIT;
                  rsp_handle_in = view.hit_handle;
                  rsp_size_in   = key_ff;
               end else begin
                  miss_in       = miss_ff + 32'd1;
                  rsp_kind_in   = fbc_pkg::KIND_MISS;
                  rsp_size_in   = key_ff;
               end
               rsp_bytes_in = cached_in;
               rsp_hits_in  = hits_in;
               rsp_miss_in  = miss_in;
            end
         end

         fbc_pkg::ST_STORE: begin
            cmd.append = 1'b1;
            state_in   = fbc_pkg::ST_COMPACT;
            if (cnt_ff == CW'(DEPTH)) begin
               // full row: oldest leaves as the new block goes in
               cmd.evict      = 1'b1;
               pend_valid_in  = 1'b1;
               pend_handle_in = view.head.handle;
               pend_size_in   = view.head.size;
               pend_bytes_in  = cached_ff - 36'(view.head.size);
               cached_in      = cached_ff - 36'(view.head.size) + 36'(size_ff);
               k_in           = CW'(1);
            end else begin
               cached_in = cached_ff + 36'(size_ff);
               cnt_in    = cnt_ff + CW'(1);
            end
         end

         fbc_pkg::ST_COMPACT: begin
            // an eviction waits in pend until we know whether another follows
            if (pend_valid_ff) begin
               if (out_free) begin
                  emit          = 1'b1;
                  rsp_kind_in   = fbc_pkg::KIND_EVICTED;
                  rsp_handle_in = pend_handle_ff;
                  rsp_size_in   = pend_size_ff;
                  rsp_bytes_in  = pend_bytes_ff;
                  rsp_last_in   = !can_evict;
                  if (can_evict) begin
                     cmd.evict      = 1'b1;
                     pend_handle_in = view.head.handle;
                     pend_size_in   = view.head.size;
                     pend_bytes_in  = cached_ff - 36'(view.head.size);
                     cached_in      = pend_bytes_in;
                     cnt_in         = cnt_ff - CW'(1);
                     k_in           = k_ff + CW'(1);
                  end else begin
                     pend_valid_in = 1'b0;
                     state_in      = fbc_pkg::ST_IDLE;
                  end
               end
            end else if (can_evict) begin
               cmd.evict      = 1'b1;
               pend_valid_in  = 1'b1;
               pend_handle_in = view.head.handle;
               pend_size_in   = view.head.size;
               pend_bytes_in  = cached_ff - 36'(view.head.size);
               cached_in      = pend_bytes_in;
               cnt_in         = cnt_ff - CW'(1);
               k_in           = k_ff + CW'(1);
            end else if (out_free) begin
               emit     = 1'b1;
               state_in = fbc_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = fbc_pkg::ST_IDLE;
         end
      endcase

      rsp_valid_in = emit ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);
   end

   fbc_array #(
      .DEPTH (DEPTH)
   ) u_array (
      .clock (clock),
      .reset (reset),
      .cmd   (cmd),
      .view  (view)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= fbc_pkg::ST_IDLE;
         clk_ff        <= '0;
         cached_ff     <= '0;
         hits_ff       <= '0;
         miss_ff       <= '0;
         cnt_ff        <= '0;
         k_ff          <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clk_ff        <= clk_in;
         cached_ff     <= cached_in;
         hits_ff       <= hits_in;
         miss_ff       <= miss_in;
         cnt_ff        <= cnt_in;
         k_ff          <= k_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff         <= key_in;
      oversize_ff    <= oversize_in;
      size_ff        <= size_in;
      handle_ff      <= handle_in;
      pend_handle_ff <= pend_handle_in;
      pend_size_ff   <= pend_size_in;
      pend_bytes_ff  <= pend_bytes_in;
      if (emit) begin
         rsp_kind_ff   <= rsp_kind_in;
         rsp_handle_ff <= rsp_handle_in;
         rsp_size_ff   <= rsp_size_in;
         rsp_bytes_ff  <= rsp_bytes_in;
         rsp_hits_ff   <= rsp_hits_in;
         rsp_miss_ff   <= rsp_miss_in;
         rsp_last_ff   <= rsp_last_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         en_ff         <= 1'b1;
         max_bytes_ff  <= '1;
         max_blocks_ff <= fbc_pkg::RST_MAX_BLOCKS;
         max_age_ff    <= '1;
      end else if (csr_we) begin
         unique case (csr_addr)
            fbc_pkg::REG_ENABLE:     en_ff         <= csr_wdata[0];
            fbc_pkg::REG_MAX_BYTES:  max_bytes_ff  <= csr_wdata;
            fbc_pkg::REG_MAX_BLOCKS: max_blocks_ff <= csr_wdata[4:0];
            fbc_pkg::REG_MAX_AGE:    max_age_ff    <= csr_wdata[31:0];
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {4'b0, rsp_miss_ff, rsp_hits_ff, rsp_bytes_ff,
                        rsp_size_ff, rsp_handle_ff};

endmodule

/* hdl/fbc_chk.sv */
module fbc_chk (
   input logic         clock,
   input logic         reset,
   input logic         req_tvalid,
   input logic         req_tready,
   input logic [1:0]   req_tuser,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [1:0]   rsp_tuser,
   input logic         rsp_tlast,
   input logic [167:0] rsp_tdata
);

   // a stalled result holds still
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=>
         rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("result changed while stalled");

   // a fetch is still being matched in the cycle after it is taken
   a_fetch_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && (req_tuser == fbc_pkg::OP_FETCH) |=> !req_tready)
      else $error("new item taken during fetch match");

   // a fetch result always closes its item
   a_fetch_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && ((rsp_tuser == fbc_pkg::KIND_HIT) || (rsp_tuser == fbc_pkg::KIND_MISS))
         |-> rsp_tlast)
      else $error("fetch result not marked last");

   // the empty result closes its item and carries no handle or size
   a_none_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == fbc_pkg::KIND_NONE)
         |-> rsp_tlast && (rsp_tdata[63:0] == 64'd0))
      else $error("bad nothing-evicted result");

endmodule

bind free_block_cache_policy_top fbc_chk u_fbc_chk (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast),
   .rsp_tdata  (rsp_tdata)
);

/* dv/free_block_cache_policy_top_tb.sv */
module free_block_cache_policy_top_tb;

   localparam int DEPTH        = 16;
   localparam int HEADER_BYTES = 16;
   localparam int SETTLE       = 6;
   localparam logic [1:0] OP_UNUSED = 2'd3;

   typedef struct {
      logic [31:0] handle;
      logic [31:0] size;
      logic [31:0] stamp;
   } held_block_type;

   typedef struct {
      fbc_pkg::fbc_kind_type kind;
      logic [31:0]  handle;
      logic [31:0]  size;
      logic [35:0]  bytes;
      logic [31:0]  hits;
      logic [31:0]  misses;
      logic         last;
   } cache_result_type;

   logic         clock;
   logic         reset      = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [1:0]   req_tuser  = '0;  // opcode
   logic [63:0]  req_tdata  = '0;  // request_bytes, block_handle
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [1:0]   rsp_tuser;        // result_kind
   logic         rsp_tlast;
   // out_handle, out_size, bytes_held, hit_count, miss_count, 4 bits zero
   logic [167:0] rsp_tdata;
   logic         csr_we     = 1'b0;
   logic [1:0]   csr_addr   = '0;
   logic [35:0]  csr_wdata  = '0;

   // predictor state, oldest block first
   held_block_type   held_blocks[$];
   cache_result_type expected_results[$];
   logic [31:0]   stamp_clock  = '0;
   logic [35:0]   bytes_cached = '0;
   logic [31:0]   hits_seen    = '0;
   logic [31:0]   misses_seen  = '0;
   logic          lim_enabled  = 1'b1;
   logic [35:0]   lim_bytes    = '1;
   logic [4:0]    lim_blocks   = fbc_pkg::RST_MAX_BLOCKS;
   logic [31:0]   lim_age      = '1;

   int error_count     = 0;
   int rsp_hold_cycles = 0;
   bit quiet           = 1'b0;

   free_block_cache_policy_top #(
      .DEPTH        (DEPTH),
      .HEADER_BYTES (HEADER_BYTES)
   ) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic void push_expected(input fbc_pkg::fbc_kind_type kind,
                                         input logic [31:0] handle,
                                         input logic [31:0] size);
      expected_results.push_back('{kind: kind, handle: handle, size: size, bytes: bytes_cached,
                                   hits: hits_seen, misses: misses_seen, last: 1'b0});
   endfunction

   function automatic bit over_limit();
      logic [31:0] age;
      if (held_blocks.size() == 0) return 1'b0;
      if (!lim_enabled) return 1'b1;
      age = stamp_clock - held_blocks[0].stamp;
      return age > lim_age || bytes_cached > lim_bytes || held_blocks.size() > int'(lim_blocks);
   endfunction

   function automatic void evict_oldest();
      held_block_type gone;
      gone = held_blocks.pop_front();
      bytes_cached = bytes_cached - {4'd0, gone.size};
      push_expected(fbc_pkg::KIND_EVICTED, gone.handle, gone.size);
   endfunction

   // evictions are capped per item, leftovers wait for the next store or compact
   function automatic int trim_to_limits(input int produced);
      int k;
      k = produced;
      while (k < DEPTH && over_limit()) begin
         evict_oldest();
         k++;
      end
      return k;
   endfunction

   function automatic void predict_fetch(input logic [31:0] bytes);
      logic [33:0] total;
      logic [33:0] fit;
      int          hit_at;
      total = {2'b00, bytes} + 34'(HEADER_BYTES);
      if (total <= fbc_pkg::SMALL_LIMIT) begin
         fit = (total + fbc_pkg::ROUND_SMALL) & ~fbc_pkg::ROUND_SMALL;
      end else begin
         fit = (total + fbc_pkg::ROUND_LARGE) & ~fbc_pkg::ROUND_LARGE;
      end
      fit = fit - 34'(HEADER_BYTES);
      if (fit[33:32] != 2'b00) begin
         misses_seen++;
         push_expected(fbc_pkg::KIND_MISS, '0, '1);
         return;
      end
      // newest block sits at the back
      hit_at = -1;
      for (int i = held_blocks.size() - 1; i >= 0; i--)
         if (hit_at < 0 && held_blocks[i].size == fit[31:0]) hit_at = i;
      if (hit_at >= 0) begin
         bytes_cached = bytes_cached - {4'd0, fit[31:0]};
         hits_seen++;
         push_expected(fbc_pkg::KIND_HIT, held_blocks[hit_at].handle, fit[31:0]);
         held_blocks.delete(hit_at);
      end else begin
         misses_seen++;
         push_expected(fbc_pkg::KIND_MISS, '0, fit[31:0]);
      end
   endfunction

   function automatic void predict_item(input logic [1:0] op, input logic [31:0] bytes,
                                        input logic [31:0] handle);
      int queued_at_start;
      int produced;
      queued_at_start = expected_results.size();
      produced = 0;
      case (op)
         fbc_pkg::OP_FETCH: predict_fetch(bytes);
         fbc_pkg::OP_STORE: begin
            stamp_clock++;
            if (held_blocks.size() >= DEPTH) begin
               evict_oldest();
               produced = 1;
            end
            held_blocks.push_back('{handle: handle, size: bytes, stamp: stamp_clock});
            bytes_cached = bytes_cached + {4'd0, bytes};
            if (trim_to_limits(produced) == 0) push_expected(fbc_pkg::KIND_NONE, '0, '0);
         end
         fbc_pkg::OP_COMPACT: begin
            if (trim_to_limits(0) == 0) push_expected(fbc_pkg::KIND_NONE, '0, '0);
         end
         default: ;
      endcase
      if (expected_results.size() > queued_at_start)
         expected_results[expected_results.size() - 1].last = 1'b1;
   endfunction

   function automatic void compare_field(input string name, input logic [35:0] want,
                                         input logic [35:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
         error_count++;
      end
   endfunction

   task automatic check_result();
      cache_result_type want;
      if (expected_results.size() == 0) begin
         $display("%0t: result with nothing expected, actual kind %0d handle %h size %h",
                  $time, rsp_tuser, rsp_tdata[31:0], rsp_tdata[63:32]);
         error_count++;
      end else begin
         want = expected_results.pop_front();
         compare_field("result_kind", want.kind, rsp_tuser);
         compare_field("out_handle", want.handle, rsp_tdata[31:0]);
         compare_field("out_size", want.size, rsp_tdata[63:32]);
         compare_field("bytes_held", want.bytes, rsp_tdata[99:64]);
         compare_field("hit_count", want.hits, rsp_tdata[131:100]);
         compare_field("miss_count", want.misses, rsp_tdata[163:132]);
         compare_field("last_result", want.last, rsp_tlast);
      end
   endtask

   // result side: random stall per item, or a long hold when one is asked for
   initial begin : result_sink
      int stall;
      while (reset) @(posedge clock);
      forever begin
         if (rsp_hold_cycles > 0) begin
            stall = rsp_hold_cycles;
            rsp_hold_cycles = 0;
         end else begin
            stall = quiet ? 0 : $urandom_range(0, 15);
         end
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         check_result();
      end
   end

   // valid stays high on return, so the caller sends again in the same step or drains
   task automatic send_item(input logic [1:0] op, input logic [31:0] bytes,
                            input logic [31:0] handle);
      int gap;
      gap = quiet ? 0 : $urandom_range(0, 15);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {handle, bytes};
      do @(posedge clock); while (!req_tready);
      predict_item(op, bytes, handle);
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (expected_results.size() != 0) @(posedge clock);
      // an ignored opcode may still be in flight
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic set_limit(input logic [1:0] addr, input logic [35:0] value);
      wait_drained();
      csr_we    <= 1'b1;
      csr_addr  <= addr;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      case (addr)
         fbc_pkg::REG_ENABLE:     lim_enabled = value[0];
         fbc_pkg::REG_MAX_BYTES:  lim_bytes   = value;
         fbc_pkg::REG_MAX_BLOCKS: lim_blocks  = value[4:0];
         fbc_pkg::REG_MAX_AGE:    lim_age     = value[31:0];
         default: ;
      endcase
   endtask

   // a block size plus a fetch request that rounds to it, or both at random
   function automatic void pick_size(output logic [31:0] size, output logic [31:0] request);
      int style;
      int k;
      style = $urandom_range(0, 19);
      if (style < 2) begin
         size    = $urandom;
         request = $urandom;
      end else if (style < 5) begin
         k       = $urandom_range(33, 40);
         size    = k * 4096 - HEADER_BYTES;
         request = size - $urandom_range(0, 4095);
      end else begin
         k       = $urandom_range(1, 9);
         size    = k * 1024 - HEADER_BYTES;
         request = size - $urandom_range(0, (k == 1) ? 1008 : 1023);
      end
   endfunction

   task automatic send_random_item();
      int          pick;
      logic [31:0] size;
      logic [31:0] request;
      pick = $urandom_range(0, 99);
      pick_size(size, request);
      if (pick < 45) send_item(fbc_pkg::OP_STORE, size, $urandom);
      else if (pick < 85) send_item(fbc_pkg::OP_FETCH, request, $urandom);
      else if (pick < 95) send_item(fbc_pkg::OP_COMPACT, $urandom, $urandom);
      else send_item(OP_UNUSED, $urandom, $urandom);
   endtask

   task automatic test_fetch_rounding();
      logic [31:0] sizes[6];
      // both sides of the 128 KiB step and of the 32-bit overflow
      sizes = '{32'd0, 32'd1009, 32'd131056, 32'd131057, 32'hFFFF_FFF0, 32'hFFFF_FFF1};
      foreach (sizes[i]) send_item(fbc_pkg::OP_FETCH, sizes[i], $urandom);
   endtask

   task automatic test_store_and_hit();
      send_item(fbc_pkg::OP_STORE, 32'd1008, 32'h0000_0000);
      send_item(fbc_pkg::OP_STORE, 32'd1008, 32'hFFFF_FFFF);
      send_item(fbc_pkg::OP_STORE, 32'hFFFF_FFFF, 32'h1234_5678);
      // newest of the two equal sizes must come back
      send_item(fbc_pkg::OP_FETCH, 32'd1000, $urandom);
      send_item(OP_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_item(fbc_pkg::OP_COMPACT, 32'd0, 32'd0);
   endtask

   task automatic test_full_table_eviction();
      for (int i = 0; i < 15; i++) begin
         send_item(fbc_pkg::OP_STORE, (i + 1) * 1024 - HEADER_BYTES, $urandom);
      end
      // disabled with a full table: one eviction for room, then the budget runs out
      set_limit(fbc_pkg::REG_ENABLE, 36'd0);
      send_item(fbc_pkg::OP_STORE, 32'd3056, $urandom);
      send_item(fbc_pkg::OP_COMPACT, $urandom, $urandom);
      set_limit(fbc_pkg::REG_ENABLE, 36'd1);
   endtask

   task automatic test_random_phase(input int idx, input int items);
      logic [35:0] value;
      case (idx)
         0: set_limit(fbc_pkg::REG_MAX_BLOCKS, 36'd0);
         1: begin
            set_limit(fbc_pkg::REG_MAX_BLOCKS, 36'd16);
            set_limit(fbc_pkg::REG_MAX_BYTES, 36'd0);
         end
         2: begin
            set_limit(fbc_pkg::REG_MAX_BYTES, 36'hF_FFFF_FFFF);
            set_limit(fbc_pkg::REG_MAX_AGE, 36'd0);
         end
         3: begin
            set_limit(fbc_pkg::REG_MAX_AGE, 36'hFFFF_FFFF);
            set_limit(fbc_pkg::REG_MAX_BLOCKS, 36'd4);
         end
         default: begin
            set_limit(fbc_pkg::REG_ENABLE, ($urandom_range(0, 9) != 0) ? 36'd1 : 36'd0);
            case ($urandom_range(0, 2))
               0: value = 36'({$urandom, $urandom});
               1: value = 36'($urandom_range(0, 2000000));
               default: value = '1;
            endcase
            set_limit(fbc_pkg::REG_MAX_BYTES, value);
            set_limit(fbc_pkg::REG_MAX_BLOCKS, 36'($urandom_range(0, 16)));
            case ($urandom_range(0, 2))
               0: value = 36'($urandom_range(0, 12));
               1: value = 36'($urandom);
               default: value = 36'hFFFF_FFFF;
            endcase
            set_limit(fbc_pkg::REG_MAX_AGE, value);
         end
      endcase
      quiet = (idx == 2) || (idx == 5);
      repeat (items) send_random_item();
      quiet = 1'b0;
   endtask

   task automatic test_output_backpressure(input int items);
      set_limit(fbc_pkg::REG_ENABLE, 36'd1);
      set_limit(fbc_pkg::REG_MAX_BLOCKS, 36'd6);
      rsp_hold_cycles = 300;
      quiet = 1'b1;
      repeat (items) send_random_item();
      quiet = 1'b0;
      wait_drained();
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_fetch_rounding();
      test_store_and_hit();
      test_full_table_eviction();
      for (int p = 0; p < 8; p++) test_random_phase(p, 15);
      test_output_backpressure(20);
      wait_drained();
      repeat (20) @(posedge clock);
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("%0t: timeout", $time);
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
